FILE: rtl/spi_pkg.sv
// ============================================================================
// spi_pkg
// Shared widths and helpers for the segment against shape intersection test.
// ============================================================================
`default_nettype none
package spi_pkg;
	localparam int COORD_BITS = 21;
	localparam int VEC_BITS   = 63;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int CROSS_BITS = 2 * COORD_BITS + 2;
	localparam int DOT_BITS   = CROSS_BITS + DIFF_BITS + 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [CROSS_BITS-1:0] crs_t;
	typedef logic signed [DOT_BITS-1:0]   dot_t;

	typedef enum logic {
		FUNC_TRIANGLE = 1'b0,
		FUNC_PARALLELOGRAM = 1'b1
	} func_t;

	function automatic coord_t get_coord(input logic [VEC_BITS-1:0] v, input int k);
		get_coord = coord_t'(v[k*COORD_BITS +: COORD_BITS]);
	endfunction
endpackage
`default_nettype wire

FILE: rtl/spi_if.sv
// ============================================================================
// spi_if
// Valid/ready channels for shape items and hit results.
// ============================================================================
`default_nettype none
interface spi_in_if
	import spi_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [VEC_BITS-1:0] shape_corner;
	logic [VEC_BITS-1:0] shape_edge_a;
	logic [VEC_BITS-1:0] shape_edge_b;
	logic [VEC_BITS-1:0] segment_start;
	logic [VEC_BITS-1:0] segment_dir;
	logic                func;
	modport source (output valid, shape_corner, shape_edge_a, shape_edge_b,
		segment_start, segment_dir, func, input ready);
	modport sink (input valid, shape_corner, shape_edge_a, shape_edge_b,
		segment_start, segment_dir, func, output ready);
endinterface

interface spi_out_if;
	logic valid;
	logic ready;
	logic hit;
	logic parallel;
	modport source (output valid, hit, parallel, input ready);
	modport sink (input valid, hit, parallel, output ready);
endinterface
`default_nettype wire

FILE: rtl/segment_polygon_intersect.sv
// ============================================================================
// segment_polygon_intersect
// Exact segment against triangle / parallelogram test by Cramer's rule.
// ============================================================================
// channel   dir  fields
// in        in   shape_corner shape_edge_a shape_edge_b segment_start segment_dir func
// out       out  hit parallel
//
// Accepted items pass through the stages below into the result register, one item a cycle when not stalled.
// Stages: differences, cross products, dot products, sign fold, compares.
// The whole pipe advances when the result register is empty or being taken;
// a stall freezes every stage, so nothing is dropped or repeated.
// arst_n clears all valid bits.
`default_nettype none
module segment_polygon_intersect
	import spi_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	spi_in_if.sink    in,
	spi_out_if.source out
);
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	coord_t a_s1 [3], b_s1 [3], l_s1 [3];
	diff_t  w_s1 [3];
	logic   f_s1, f_s2, f_s3, f_s4;

	crs_t   n_s2 [3], bl_s2 [3], la_s2 [3];
	diff_t  w_s2 [3];
	coord_t l_s2 [3];

	dot_t   d_s3, nu_s3, nv_s3, nw_s3;
	dot_t   d_s4, nu_s4, nv_s4, nt_s4;
	logic   par_s4;
	logic   hit_s5, par_s5;

	assign adv = !v_s5 || out.ready;
	assign in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in.valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				a_s1[k] <= get_coord(in.shape_edge_a, k);
				b_s1[k] <= get_coord(in.shape_edge_b, k);
				l_s1[k] <= get_coord(in.segment_dir, k);
				w_s1[k] <= diff_t'(get_coord(in.segment_start, k))
					- diff_t'(get_coord(in.shape_corner, k));
			end
			f_s1 <= in.func;
			// cross products
			for (int k = 0; k < 3; k++) begin
				n_s2[k]  <= crs_t'(a_s1[(k+1)%3]) * crs_t'(b_s1[(k+2)%3])
					- crs_t'(a_s1[(k+2)%3]) * crs_t'(b_s1[(k+1)%3]);
				bl_s2[k] <= crs_t'(b_s1[(k+1)%3]) * crs_t'(l_s1[(k+2)%3])
					- crs_t'(b_s1[(k+2)%3]) * crs_t'(l_s1[(k+1)%3]);
				la_s2[k] <= crs_t'(l_s1[(k+1)%3]) * crs_t'(a_s1[(k+2)%3])
					- crs_t'(l_s1[(k+2)%3]) * crs_t'(a_s1[(k+1)%3]);
				w_s2[k] <= w_s1[k];
				l_s2[k] <= l_s1[k];
			end
			f_s2 <= f_s1;
			// dot products
			d_s3  <= dot_t'(l_s2[0]) * dot_t'(n_s2[0]) + dot_t'(l_s2[1]) * dot_t'(n_s2[1])
				+ dot_t'(l_s2[2]) * dot_t'(n_s2[2]);
			nu_s3 <= dot_t'(w_s2[0]) * dot_t'(bl_s2[0]) + dot_t'(w_s2[1]) * dot_t'(bl_s2[1])
				+ dot_t'(w_s2[2]) * dot_t'(bl_s2[2]);
			nv_s3 <= dot_t'(w_s2[0]) * dot_t'(la_s2[0]) + dot_t'(w_s2[1]) * dot_t'(la_s2[1])
				+ dot_t'(w_s2[2]) * dot_t'(la_s2[2]);
			nw_s3 <= dot_t'(w_s2[0]) * dot_t'(n_s2[0]) + dot_t'(w_s2[1]) * dot_t'(n_s2[1])
				+ dot_t'(w_s2[2]) * dot_t'(n_s2[2]);
			f_s3 <= f_s2;
			// fold sign of determinant
			par_s4 <= (d_s3 == '0);
			if (d_s3[DOT_BITS-1]) begin
				d_s4 <= -d_s3; nu_s4 <= -nu_s3; nv_s4 <= -nv_s3; nt_s4 <= nw_s3;
			end else begin
				d_s4 <= d_s3; nu_s4 <= nu_s3; nv_s4 <= nv_s3; nt_s4 <= -nw_s3;
			end
			f_s4 <= f_s3;
			// bounds
			par_s5 <= par_s4;
			if (par_s4) begin
				hit_s5 <= 1'b0;
			end else if (func_t'(f_s4) == FUNC_PARALLELOGRAM) begin
				hit_s5 <= !nu_s4[DOT_BITS-1] && !nv_s4[DOT_BITS-1] && !nt_s4[DOT_BITS-1]
					&& nt_s4 <= d_s4 && nu_s4 <= d_s4 && nv_s4 <= d_s4;
			end else begin
				hit_s5 <= !nu_s4[DOT_BITS-1] && !nv_s4[DOT_BITS-1] && !nt_s4[DOT_BITS-1]
					&& nt_s4 <= d_s4 && (nu_s4 + nv_s4) <= d_s4;
			end
		end
	end

	assign out.valid    = v_s5;
	assign out.hit      = hit_s5;
	assign out.parallel = par_s5;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.hit) && $stable(out.parallel))
		else $error("result changed under stall");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> !(out.hit && out.parallel))
		else $error("hit reported on parallel item");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in.ready |=> v_s1 == $past(in.valid))
		else $error("stage one valid lost");
endmodule
`default_nettype wire

FILE: tb/segment_polygon_intersect_tb.sv
// ============================================================================
// segment_polygon_intersect_tb
// Streams shape/segment items through the intersection pipe with random
// idling on both sides, predicts hit and parallel flags by exact integer
// Cramer's rule and compares every result item in order.
// ============================================================================
`default_nettype none
module segment_polygon_intersect_tb
	import spi_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [VEC_BITS-1:0] vec_t;
	typedef logic signed [127:0] big_t;

	typedef struct {
		vec_t  c, a, b, s, l;
		func_t fn;
		logic  chk;
		logic  hit, par;
	} row_t;

	typedef struct {
		logic hit, par;
	} flags_t;

	localparam int   CYCLE_LIMIT = 200000;
	localparam int   N_RANDOM    = 1530;
	localparam vec_t ZERO_V      = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	spi_in_if  in_ch();
	spi_out_if out_ch();

	segment_polygon_intersect u_top (.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	flags_t awaited[$];
	int     errors = 0;
	int     cycles = 0;
	bit     calm = 0;
	bit     hold_long = 0;
	row_t   dir_rows[$];

	function automatic vec_t pack3(int x, int y, int z);
		vec_t v;
		v[COORD_BITS-1:0] = x[COORD_BITS-1:0];
		v[2*COORD_BITS-1:COORD_BITS] = y[COORD_BITS-1:0];
		v[3*COORD_BITS-1:2*COORD_BITS] = z[COORD_BITS-1:0];
		return v;
	endfunction

	function automatic big_t crd(vec_t v, int k);
		logic signed [COORD_BITS-1:0] f;
		f = v[k*COORD_BITS +: COORD_BITS];
		return big_t'(f);
	endfunction

	function automatic flags_t intersect_flags(vec_t c, vec_t a, vec_t b, vec_t s, vec_t l,
			func_t fn);
		big_t av[3], bv[3], lv[3], wv[3], nv_[3], blv[3], lav[3];
		big_t det, nu, nv, nt;
		flags_t r;
		for (int k = 0; k < 3; k++) begin
			av[k] = crd(a, k); bv[k] = crd(b, k); lv[k] = crd(l, k);
			wv[k] = crd(s, k) - crd(c, k);
		end
		for (int k = 0; k < 3; k++) begin
			int i, j;
			i = (k + 1) % 3; j = (k + 2) % 3;
			nv_[k] = av[i] * bv[j] - av[j] * bv[i];
			blv[k] = bv[i] * lv[j] - bv[j] * lv[i];
			lav[k] = lv[i] * av[j] - lv[j] * av[i];
		end
		det = lv[0]*nv_[0] + lv[1]*nv_[1] + lv[2]*nv_[2];
		r.par = (det == 0);
		r.hit = 1'b0;
		if (!r.par) begin
			nu = wv[0]*blv[0] + wv[1]*blv[1] + wv[2]*blv[2];
			nv = wv[0]*lav[0] + wv[1]*lav[1] + wv[2]*lav[2];
			nt = -(wv[0]*nv_[0] + wv[1]*nv_[1] + wv[2]*nv_[2]);
			if (det < 0) begin
				det = -det; nu = -nu; nv = -nv; nt = -nt;
			end
			r.hit = nu >= 0 && nv >= 0 && nt >= 0 && nt <= det;
			if (fn == FUNC_PARALLELOGRAM)
				r.hit = r.hit && nu <= det && nv <= det;
			else
				r.hit = r.hit && nu + nv <= det;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic got, logic want);
		$display("mismatch %s: got %0b want %0b at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	function automatic vec_t rand_vec(int mag);
		int x, y, z;
		vec_t v;
		x = $urandom_range(2*mag) - mag;
		y = $urandom_range(2*mag) - mag;
		z = $urandom_range(2*mag) - mag;
		v = pack3(x, y, z);
		return v;
	endfunction

	task automatic add_row(vec_t c, vec_t a, vec_t b, vec_t s, vec_t l, func_t fn,
			logic chk, logic h, logic p);
		row_t r;
		r.c = c; r.a = a; r.b = b; r.s = s; r.l = l; r.fn = fn;
		r.chk = chk; r.hit = h; r.par = p;
		dir_rows.push_back(r);
	endtask

	task automatic send_item(vec_t c, vec_t a, vec_t b, vec_t s, vec_t l, func_t fn);
		if (!calm && $urandom_range(5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.shape_corner <= c; in_ch.shape_edge_a <= a; in_ch.shape_edge_b <= b;
		in_ch.segment_start <= s; in_ch.segment_dir <= l; in_ch.func <= fn;
		do @(posedge clk); while (!in_ch.ready);
		awaited.push_back(intersect_flags(c, a, b, s, l, fn));
	endtask

	// sink side
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_ch.ready <= 1'b0;
				repeat (60) @(posedge clk);
				hold_long = 0;
			end
			if (!calm && $urandom_range(4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (awaited.size() == 0) begin
				$display("unexpected result item at cycle %0d", cycles);
				errors++;
			end else begin
				flags_t e;
				e = awaited.pop_front();
				if (out_ch.hit !== e.hit) report_mismatch("hit", out_ch.hit, e.hit);
				if (out_ch.parallel !== e.par)
					report_mismatch("parallel", out_ch.parallel, e.par);
			end
		end
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int mx, mn;
		vec_t c, a, b, s, l;
		vec_t all1;
		mx = (1 << (COORD_BITS-1)) - 1;
		mn = -(1 << (COORD_BITS-1));
		all1 = '1;
		in_ch.valid <= 1'b0;
		in_ch.shape_corner <= '0; in_ch.shape_edge_a <= '0; in_ch.shape_edge_b <= '0;
		in_ch.segment_start <= '0; in_ch.segment_dir <= '0; in_ch.func <= 1'b0;

		// all zero: degenerate
		add_row(ZERO_V, ZERO_V, ZERO_V, ZERO_V, ZERO_V, FUNC_TRIANGLE, 1, 0, 1);
		// unit triangle in z=0, segment through (0.25,0.25)
		add_row(ZERO_V, pack3(4,0,0), pack3(0,4,0), pack3(1,1,2), pack3(0,0,-4),
			FUNC_TRIANGLE, 1, 1, 0);
		// corner, and a point on the hypotenuse edge (bounds inclusive)
		add_row(ZERO_V, pack3(4,0,0), pack3(0,4,0), pack3(0,0,1), pack3(0,0,-2),
			FUNC_TRIANGLE, 1, 1, 0);
		add_row(ZERO_V, pack3(4,0,0), pack3(0,4,0), pack3(2,2,1), pack3(0,0,-2),
			FUNC_TRIANGLE, 1, 1, 0);
		// outside triangle but inside parallelogram
		add_row(ZERO_V, pack3(4,0,0), pack3(0,4,0), pack3(3,3,1), pack3(0,0,-2),
			FUNC_TRIANGLE, 1, 0, 0);
		add_row(ZERO_V, pack3(4,0,0), pack3(0,4,0), pack3(3,3,1), pack3(0,0,-2),
			FUNC_PARALLELOGRAM, 1, 1, 0);
		add_row(ZERO_V, pack3(4,0,0), pack3(0,4,0), pack3(4,4,1), pack3(0,0,-2),
			FUNC_PARALLELOGRAM, 1, 1, 0);
		// segment ends touching the plane, and falling short
		add_row(ZERO_V, pack3(4,0,0), pack3(0,4,0), pack3(1,1,2), pack3(0,0,-2),
			FUNC_TRIANGLE, 1, 1, 0);
		add_row(ZERO_V, pack3(4,0,0), pack3(0,4,0), pack3(1,1,3), pack3(0,0,-2),
			FUNC_TRIANGLE, 1, 0, 0);
		add_row(ZERO_V, pack3(4,0,0), pack3(0,4,0), pack3(1,1,0), pack3(0,0,2),
			FUNC_TRIANGLE, 1, 1, 0);
		// negative u
		add_row(ZERO_V, pack3(4,0,0), pack3(0,4,0), pack3(-1,1,1), pack3(0,0,-2),
			FUNC_PARALLELOGRAM, 1, 0, 0);
		// segment parallel to the plane, and zero length
		add_row(ZERO_V, pack3(4,0,0), pack3(0,4,0), pack3(1,1,1), pack3(3,1,0),
			FUNC_TRIANGLE, 1, 0, 1);
		add_row(ZERO_V, pack3(4,0,0), pack3(0,4,0), pack3(1,1,0), ZERO_V,
			FUNC_PARALLELOGRAM, 1, 0, 1);
		// degenerate shape
		add_row(ZERO_V, pack3(4,0,0), pack3(8,0,0), pack3(1,1,1), pack3(0,0,-2),
			FUNC_TRIANGLE, 1, 0, 1);
		// extremes of the coordinates, predicted
		add_row(pack3(mn,mn,mn), pack3(mx,mx,mn), pack3(mn,mx,mx), pack3(mx,mx,mx),
			pack3(mn,mn,mx), FUNC_TRIANGLE, 0, 0, 0);
		add_row(pack3(mx,mn,mx), pack3(mx,0,0), pack3(0,mx,0), pack3(mx,mn,mx),
			pack3(mn,mn,mn), FUNC_PARALLELOGRAM, 0, 0, 0);
		add_row(all1, all1, all1, all1, all1, FUNC_PARALLELOGRAM, 1, 0, 1);
		add_row(pack3(mn,mn,mn), pack3(mx,0,0), pack3(0,mx,0), pack3(mn,mn,mx),
			pack3(0,0,mn), FUNC_PARALLELOGRAM, 0, 0, 0);
		// top bit is the sign of the corner's z coordinate, predicted
		add_row(vec_t'(1) << (VEC_BITS-1), pack3(4,0,0), pack3(0,4,0),
			pack3(1,1,2), pack3(0,0,-4), FUNC_TRIANGLE, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row_t r;
			r = dir_rows[i];
			send_item(r.c, r.a, r.b, r.s, r.l, r.fn);
			if (r.chk) begin
				flags_t e;
				e = intersect_flags(r.c, r.a, r.b, r.s, r.l, r.fn);
				if (e.hit !== r.hit) report_mismatch("table hit", e.hit, r.hit);
				if (e.par !== r.par) report_mismatch("table parallel", e.par, r.par);
			end
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			int kind, mag;
			func_t fn;
			fn = func_t'($urandom_range(1));
			if (n == 300) hold_long = 1;
			if (n == 700) begin
				in_ch.valid <= 1'b0;
				wait (awaited.size() == 0);
				@(posedge clk);
			end
			if (n == N_RANDOM - 200) calm = 1;
			kind = $urandom_range(9);
			mag = (kind < 5) ? 64 : (kind < 7) ? 4096 : (1 << (COORD_BITS-1));
			if (kind == 9) begin
				c = vec_t'({$urandom, $urandom}); a = vec_t'({$urandom, $urandom});
				b = vec_t'({$urandom, $urandom}); s = vec_t'({$urandom, $urandom});
				l = vec_t'({$urandom, $urandom});
			end else begin
				c = rand_vec(mag); a = rand_vec(mag); b = rand_vec(mag);
				if (kind < 6) begin
					// aim the segment near the shape so hits are common
					int u4, v4, tq;
					vec_t p;
					u4 = $urandom_range(5); v4 = $urandom_range(5);
					tq = $urandom_range(1, 3);
					p = pack3(int'(crd(c,0) + (u4*crd(a,0) + v4*crd(b,0))/4),
						int'(crd(c,1) + (u4*crd(a,1) + v4*crd(b,1))/4),
						int'(crd(c,2) + (u4*crd(a,2) + v4*crd(b,2))/4));
					l = rand_vec(mag);
					s = pack3(int'(crd(p,0) - (tq*crd(l,0))/4),
						int'(crd(p,1) - (tq*crd(l,1))/4),
						int'(crd(p,2) - (tq*crd(l,2))/4));
				end else begin
					s = rand_vec(mag); l = rand_vec(mag);
				end
			end
			send_item(c, a, b, s, l, fn);
		end
		in_ch.valid <= 1'b0;
		wait (awaited.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
